/* hdl/periodic_image_wrap_macros.svh */
// Assertion macros shared by the periodic wrap checker.
`ifndef PERIODIC_IMAGE_WRAP_MACROS_SVH
`define PERIODIC_IMAGE_WRAP_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define PIW_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is high.
`define PIW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define PIW_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/piw_pkg.sv */
// Package for the periodic wrap block: widths, register indexes and word types.
package piw_pkg;

  localparam int COORD_WIDTH    = 32;
  localparam int NAXES          = 3;
  localparam int LEN_WIDTH      = 31;
  localparam int INV_WIDTH      = 32;
  localparam int AXES_WIDTH     = 3;
  // Q16.16 times Q1.31 leaves 47 fraction bits
  localparam int ROUND_SHIFT    = 47;
  localparam int PIPE_STAGES    = 8;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 32;

  // Register indexes of the write port
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LENGTH_X  = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LENGTH_Y  = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LENGTH_Z  = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_INVERSE_X = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_INVERSE_Y = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_INVERSE_Z = 3'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PERIODIC  = 3'd6;

  // Reset values
  localparam logic [LEN_WIDTH-1:0]  LENGTH_RESET  = 31'd65536;
  localparam logic [INV_WIDTH-1:0]  INVERSE_RESET = 32'h8000_0000;
  localparam logic [AXES_WIDTH-1:0] PERIODIC_RESET = 3'd0;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
    logic signed [COORD_WIDTH-1:0] ref_x;
    logic signed [COORD_WIDTH-1:0] ref_y;
    logic signed [COORD_WIDTH-1:0] ref_z;
  } point_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
  } result_t;

endpackage

/* hdl/periodic_image_wrap.sv */
// Top level of the periodic wrap block: eight-stage minimum-image pipeline.
//
//   channel  | handshake         | payload
//   ---------+-------------------+-----------------------------
//   point    | start / busy      | point_t  (pos_x..ref_z)
//   result   | done (one cycle)  | result_t (out_x..out_z)
//   config   | cfg_we            | cfg_index, cfg_data
//
// One word enters per cycle while busy is low; each result leaves after its word
// has passed through the pipeline stages (difference, inverse multiply, sum, round,
// length multiply, sum, saturate and select).
// Synchronous reset clears the valid bits and holds busy high; busy is registered
// and clears after reset falls. The receiver cannot stall, so the pipeline never waits.
module periodic_image_wrap (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  piw_pkg::point_t                        point,
  output logic                                   done,
  output piw_pkg::result_t                       result,
  input  logic                                   cfg_we,
  input  logic [piw_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [piw_pkg::CFG_DATA_WIDTH-1:0]     cfg_data
);
  import piw_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int DW   = W + 1;
  localparam int MCH  = (DW + 31) / 32;
  localparam int MPAD = MCH * 32;
  localparam int PPW  = 32 + INV_WIDTH;
  localparam int PW   = MPAD + 32;
  localparam int QW   = W + INV_WIDTH - ROUND_SHIFT + 1;
  localparam int QCH  = (QW + 31) / 32;
  localparam int QPAD = QCH * 32;
  localparam int LPW  = 32 + LEN_WIDTH;
  localparam int MSW  = QPAD + LEN_WIDTH;

  localparam logic [W-1:0] COORD_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] COORD_MAX = {1'b0, {(W-1){1'b1}}};

  // Configuration registers
  logic [LEN_WIDTH-1:0]  length   [NAXES];
  logic [INV_WIDTH-1:0]  inverse  [NAXES];
  logic [AXES_WIDTH-1:0] periodic;

  // Pipeline registers
  logic [PIPE_STAGES-1:0] vld;
  logic [W-1:0]   pos1 [NAXES];
  logic [W-1:0]   ref1 [NAXES];
  logic [W-1:0]   pos2 [NAXES];
  logic [W-1:0]   pos3 [NAXES];
  logic [W-1:0]   pos4 [NAXES];
  logic [W-1:0]   pos5 [NAXES];
  logic [W-1:0]   pos6 [NAXES];
  logic [W-1:0]   pos7 [NAXES];
  logic           neg2 [NAXES];
  logic           neg3 [NAXES];
  logic           neg4 [NAXES];
  logic           neg5 [NAXES];
  logic           neg6 [NAXES];
  logic           neg7 [NAXES];
  logic [DW-1:0]  mag2 [NAXES];
  logic [PPW-1:0] pp3  [NAXES][MCH];
  logic [PW-1:0]  prod4 [NAXES];
  logic [QW-1:0]  q5   [NAXES];
  logic [LPW-1:0] pp6  [NAXES][QCH];
  logic [MSW-1:0] m7   [NAXES];

  // Next values
  logic [DW-1:0]   diff_fwd   [NAXES];
  logic [DW-1:0]   diff_rev   [NAXES];
  logic            neg_next   [NAXES];
  logic [DW-1:0]   mag_next   [NAXES];
  logic [MPAD-1:0] mag_pad    [NAXES];
  logic [PPW-1:0]  pp3_next   [NAXES][MCH];
  logic [PW-1:0]   prod_next  [NAXES];
  logic [QW-1:0]   q_raw      [NAXES];
  logic            round_up   [NAXES];
  logic [QW-1:0]   q_next     [NAXES];
  logic [QPAD-1:0] q_pad      [NAXES];
  logic [LPW-1:0]  pp6_next   [NAXES][QCH];
  logic [MSW-1:0]  m_next     [NAXES];
  logic [W-1:0]    room       [NAXES];
  logic [W-1:0]    out_next   [NAXES];

  logic accept;

  assign accept = start && !busy;
  assign done   = vld[PIPE_STAGES-1];

  // Hold busy high during reset; it clears once reset falls
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < NAXES; a++) begin
        length[a]  <= LENGTH_RESET;
        inverse[a] <= INVERSE_RESET;
      end
      periodic <= PERIODIC_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LENGTH_X:  length[0]  <= cfg_data[LEN_WIDTH-1:0];
        REG_LENGTH_Y:  length[1]  <= cfg_data[LEN_WIDTH-1:0];
        REG_LENGTH_Z:  length[2]  <= cfg_data[LEN_WIDTH-1:0];
        REG_INVERSE_X: inverse[0] <= cfg_data[INV_WIDTH-1:0];
        REG_INVERSE_Y: inverse[1] <= cfg_data[INV_WIDTH-1:0];
        REG_INVERSE_Z: inverse[2] <= cfg_data[INV_WIDTH-1:0];
        REG_PERIODIC:  periodic   <= cfg_data[AXES_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_STAGES-2:0], accept};
    end
  end

  // Stage 2: signed difference and its magnitude
  always_comb begin
    for (int a = 0; a < NAXES; a++) begin
      diff_fwd[a] = {pos1[a][W-1], pos1[a]} - {ref1[a][W-1], ref1[a]};
      diff_rev[a] = {ref1[a][W-1], ref1[a]} - {pos1[a][W-1], pos1[a]};
      neg_next[a] = diff_fwd[a][DW-1];
      mag_next[a] = neg_next[a] ? diff_rev[a] : diff_fwd[a];
    end
  end

  // Stage 3: partial products of magnitude by inverse length
  always_comb begin
    for (int a = 0; a < NAXES; a++) begin
      mag_pad[a] = MPAD'(mag2[a]);
      for (int k = 0; k < MCH; k++) begin
        pp3_next[a][k] = PPW'(mag_pad[a][k*32 +: 32]) * PPW'(inverse[a]);
      end
    end
  end

  // Stage 4: sum partial products
  always_comb begin
    for (int a = 0; a < NAXES; a++) begin
      prod_next[a] = '0;
      for (int k = 0; k < MCH; k++) begin
        prod_next[a] = prod_next[a] + (PW'(pp3[a][k]) << (32 * k));
      end
    end
  end

  // Stage 5: round image count to nearest, ties to even
  always_comb begin
    for (int a = 0; a < NAXES; a++) begin
      q_raw[a]    = prod4[a][ROUND_SHIFT +: QW];
      round_up[a] = prod4[a][ROUND_SHIFT-1] &&
                    ((|prod4[a][ROUND_SHIFT-2:0]) || q_raw[a][0]);
      q_next[a]   = q_raw[a] + QW'(round_up[a]);
    end
  end

  // Stage 6: partial products of count by box length
  always_comb begin
    for (int a = 0; a < NAXES; a++) begin
      q_pad[a] = QPAD'(q5[a]);
      for (int k = 0; k < QCH; k++) begin
        pp6_next[a][k] = LPW'(q_pad[a][k*32 +: 32]) * LPW'(length[a]);
      end
    end
  end

  // Stage 7: sum shift amount
  always_comb begin
    for (int a = 0; a < NAXES; a++) begin
      m_next[a] = '0;
      for (int k = 0; k < QCH; k++) begin
        m_next[a] = m_next[a] + (MSW'(pp6[a][k]) << (32 * k));
      end
    end
  end

  // Stage 8: apply shift toward reference, saturate, drop non-periodic axes
  always_comb begin
    for (int a = 0; a < NAXES; a++) begin
      // distance from the most negative code
      room[a] = {~pos7[a][W-1], pos7[a][W-2:0]};
      if (!periodic[a]) begin
        out_next[a] = pos7[a];
      end else if (!neg7[a]) begin
        out_next[a] = (m7[a] > MSW'(room[a])) ? COORD_MIN : (pos7[a] - m7[a][W-1:0]);
      end else begin
        out_next[a] = (m7[a] > {{(MSW-W){1'b0}}, ~room[a]}) ? COORD_MAX :
                      (pos7[a] + m7[a][W-1:0]);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pos1[0] <= point.pos_x;
    pos1[1] <= point.pos_y;
    pos1[2] <= point.pos_z;
    ref1[0] <= point.ref_x;
    ref1[1] <= point.ref_y;
    ref1[2] <= point.ref_z;
    for (int a = 0; a < NAXES; a++) begin
      pos2[a] <= pos1[a];
      neg2[a] <= neg_next[a];
      mag2[a] <= mag_next[a];
      pos3[a] <= pos2[a];
      neg3[a] <= neg2[a];
      for (int k = 0; k < MCH; k++) begin
        pp3[a][k] <= pp3_next[a][k];
      end
      pos4[a]  <= pos3[a];
      neg4[a]  <= neg3[a];
      prod4[a] <= prod_next[a];
      pos5[a]  <= pos4[a];
      neg5[a]  <= neg4[a];
      q5[a]    <= q_next[a];
      pos6[a]  <= pos5[a];
      neg6[a]  <= neg5[a];
      for (int k = 0; k < QCH; k++) begin
        pp6[a][k] <= pp6_next[a][k];
      end
      pos7[a] <= pos6[a];
      neg7[a] <= neg6[a];
      m7[a]   <= m_next[a];
    end
    result.out_x <= out_next[0];
    result.out_y <= out_next[1];
    result.out_z <= out_next[2];
  end

endmodule

/* hdl/piw_checker.sv */
// Port-level checker for the periodic wrap block, bound to its top level.
`include "periodic_image_wrap_macros.svh"

module piw_port_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);
  import piw_pkg::*;

  // Every result comes from a word taken a fixed latency earlier
  `PIW_ASSERT_IMPLY(a_done_has_word, done, $past(start && !busy, PIPE_STAGES), "result without word")

  // Reset raises busy
  `PIW_ASSERT_NEXT_ALWAYS(a_busy_after_rst, rst, busy, "busy low after reset")

  // Once running, the block never refuses a word
  `PIW_ASSERT_NEXT(a_never_stall, !busy, !busy, "busy rose outside reset")

endmodule

bind periodic_image_wrap piw_port_checker u_piw_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
